// ===== hdl/nav_pkg.sv =====
package nav_pkg;

    localparam int FIELD_W       = 32;
    localparam int ENTRY_INDEX_W = 10;
    localparam int TABLE_SIZE_W  = 11;
    localparam int MAX_GAP_W     = 31;
    localparam int CFG_INDEX_W   = 4;

    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;
    localparam logic [MAX_GAP_W-1:0]    MAX_GAP_RST    = 31'd65536;

    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIZE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GAP    = 4'd1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD0,
        ST_HEAD1,
        ST_HEAD2,
        ST_SCAN,
        ST_EMIT
    } nav_state_t;

endpackage

// ===== hdl/nav_axis_store.sv =====
module nav_axis_store #(
    parameter int DEPTH = 1024,
    parameter int VW    = 32,
    parameter int AW    = 10
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [VW-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    input  logic signed [VW-1:0] query,
    output logic signed [VW-1:0] rd_data_reg,
    output logic [VW-1:0]        diff_reg
);
    import nav_pkg::*;

    logic signed [VW-1:0] mem [DEPTH];
    logic signed [VW:0]   q_minus_e;
    logic signed [VW:0]   e_minus_q;
    logic [VW-1:0]        diff_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // absolute difference of query and the entry just read
    always_comb begin
        q_minus_e = {query[VW-1], query} - {rd_data_reg[VW-1], rd_data_reg};
        e_minus_q = {rd_data_reg[VW-1], rd_data_reg} - {query[VW-1], query};
        diff_next = q_minus_e[VW] ? e_minus_q[VW-1:0] : q_minus_e[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
    end

endmodule

// ===== hdl/nearest_axis_value_search.sv =====
// Nearest axis value search. A load beat (req_type 0) writes one signed entry of the axis
// table; entries never written must not be reached by a query. A query beat (req_type 1)
// walks the table from index 0 through a RAM with separate read and write ports, one
// entry per cycle: it reads entry 0 and entry n-1, where n is table_size clamped to
// 1..TABLE_DEPTH, and fixes the direction, then reads each entry in turn through the
// read and difference registers to the compare, then hands over the result. The walk
// ends early at the first entry that no longer improves once a match is held. The
// input accepts a new beat whenever no query is in flight; a result waiting on the
// output only holds back the handover of the next query's result.
module nearest_axis_value_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [nav_pkg::ENTRY_INDEX_W-1:0]   s_entry_index,
    input  logic signed [nav_pkg::FIELD_W-1:0]  s_entry_value,
    input  logic signed [nav_pkg::FIELD_W-1:0]  s_query_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [nav_pkg::ENTRY_INDEX_W-1:0]   m_found_index,
    output logic                                m_found,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nav_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nav_pkg::FIELD_W-1:0]         cfg_data
);
    import nav_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = (VALUE_WIDTH > MAX_GAP_W) ? VALUE_WIDTH : MAX_GAP_W;

    nav_state_t state_reg, state_next;

    logic [TABLE_SIZE_W-1:0]       table_size_reg;
    logic [MAX_GAP_W-1:0]          max_gap_reg;

    logic signed [VALUE_WIDTH-1:0] query_reg;
    logic signed [VALUE_WIDTH-1:0] first_reg;
    logic                          ascending_reg;
    logic [CW-1:0]                 n_reg;
    logic [AW-1:0]                 last_reg;
    logic [CW-1:0]                 iss_reg;
    logic                          v1_reg, v2_reg;
    logic [AW-1:0]                 i1_reg, i2_reg;
    logic [DW-1:0]                 best_reg;
    logic [AW-1:0]                 best_idx_reg;
    logic                          have_reg;

    logic                          m_valid_reg;
    logic [ENTRY_INDEX_W-1:0]      m_found_index_reg;
    logic                          m_found_reg;

    logic                          s_fire;
    logic                          load_fire;
    logic                          query_fire;
    logic [31:0]                   idx_ext;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic signed [63:0]            entry_ext;
    logic signed [63:0]            query_ext;
    logic [31:0]                   ts_ext;
    logic [31:0]                   n_ext;
    logic [31:0]                   last_ext;
    logic [31:0]                   best_idx_ext;

    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          issue;
    logic signed [VALUE_WIDTH-1:0] rd_data;
    logic [VALUE_WIDTH-1:0]        diff;
    logic [DW-1:0]                 cmp_diff;
    logic                          better;
    logic                          scan_done;
    logic                          emit;

    assign cfg_ready  = 1'b1;
    assign s_fire     = s_valid && s_ready;
    assign load_fire  = s_fire && (s_req_type == REQ_LOAD);
    assign query_fire = s_fire && (s_req_type == REQ_QUERY);

    always_comb begin
        idx_ext   = 32'(s_entry_index);
        wr_en     = load_fire && (idx_ext < 32'(TABLE_DEPTH));
        wr_addr   = idx_ext[AW-1:0];
        entry_ext = 64'(s_entry_value);
        query_ext = 64'(s_query_value);
        ts_ext    = 32'(table_size_reg);
        if (ts_ext == 32'd0) begin
            n_ext = 32'd1;
        end else if (ts_ext > 32'(TABLE_DEPTH)) begin
            n_ext = 32'(TABLE_DEPTH);
        end else begin
            n_ext = ts_ext;
        end
        last_ext     = n_ext - 32'd1;
        best_idx_ext = 32'(best_idx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= TABLE_SIZE_RST;
            max_gap_reg    <= MAX_GAP_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TABLE_SIZE: table_size_reg <= cfg_data[TABLE_SIZE_W-1:0];
                CFG_MAX_GAP:    max_gap_reg    <= cfg_data[MAX_GAP_W-1:0];
                default: ;
            endcase
        end
    end

    nav_axis_store #(
        .DEPTH (TABLE_DEPTH),
        .VW    (VALUE_WIDTH),
        .AW    (AW)
    ) u_store (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (entry_ext[VALUE_WIDTH-1:0]),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .query       (query_reg),
        .rd_data_reg (rd_data),
        .diff_reg    (diff)
    );

    // compare stage
    always_comb begin
        cmp_diff  = DW'(diff);
        better    = ascending_reg ? (cmp_diff <= best_reg) : (cmp_diff < best_reg);
        scan_done = 1'b0;
        if (state_reg == ST_SCAN && v2_reg) begin
            if (better) begin
                scan_done = (i2_reg == last_reg);
            end else begin
                scan_done = have_reg || (i2_reg == last_reg);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (query_fire) state_next = ST_HEAD0;
            ST_HEAD0: state_next = ST_HEAD1;
            ST_HEAD1: state_next = ST_HEAD2;
            ST_HEAD2: state_next = ST_SCAN;
            ST_SCAN:  if (scan_done) state_next = ST_EMIT;
            ST_EMIT:  if (emit) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        rd_addr = iss_reg[AW-1:0];
        issue   = 1'b0;
        emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_HEAD0: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ST_HEAD1: begin
                rd_en   = 1'b1;
                rd_addr = last_reg;
            end
            ST_HEAD2: ;
            ST_SCAN: begin
                issue = (iss_reg < n_reg) && !scan_done;
                rd_en = issue;
            end
            ST_EMIT:  emit = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            iss_reg   <= '0;
            have_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (query_fire) begin
                iss_reg  <= '0;
                have_reg <= 1'b0;
            end else if (issue) begin
                iss_reg <= iss_reg + CW'(1);
            end
            if (scan_done) begin
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
            end else begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
            end
            if (state_reg == ST_SCAN && v2_reg && better) begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (query_fire) begin
            query_reg    <= query_ext[VALUE_WIDTH-1:0];
            n_reg        <= n_ext[CW-1:0];
            last_reg     <= last_ext[AW-1:0];
            best_reg     <= DW'(max_gap_reg);
            best_idx_reg <= '0;
        end
        if (state_reg == ST_HEAD1) begin
            first_reg <= rd_data;
        end
        if (state_reg == ST_HEAD2) begin
            ascending_reg <= first_reg < rd_data;
        end
        i1_reg <= iss_reg[AW-1:0];
        i2_reg <= i1_reg;
        if (state_reg == ST_SCAN && v2_reg && better) begin
            best_reg     <= cmp_diff;
            best_idx_reg <= i2_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_found_reg       <= have_reg;
            m_found_index_reg <= have_reg ? best_idx_ext[ENTRY_INDEX_W-1:0] : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_found_index = m_found_index_reg;

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !v1_reg && !v2_reg)
        else $error("scan pipeline busy while idle");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> iss_reg <= n_reg)
        else $error("read issue past table size");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> i2_reg <= last_reg)
        else $error("compared entry beyond last");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_found_index == '0)
        else $error("miss result carries an index");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && m_valid_reg && !m_ready |=> state_reg == ST_EMIT)
        else $error("result overwritten before taken");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import nav_pkg::*;

    typedef struct packed {
        logic                      req_type;
        logic [ENTRY_INDEX_W-1:0]  entry_index;
        logic signed [FIELD_W-1:0] entry_value;
        logic signed [FIELD_W-1:0] query_value;
    } axis_beat_t;

    typedef struct packed {
        logic [ENTRY_INDEX_W-1:0] found_index;
        logic                     found;
    } lookup_result_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    localparam int DEPTH = 1024;
    localparam int RANDOM_ITEMS = 540;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 4'd15;
    localparam longint VALUE_MIN = -64'sd2147483648;
    localparam longint VALUE_MAX = 64'sd2147483647;
    localparam longint SPAN_MAX = 64'sd4294967295;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_req_type = REQ_LOAD;
    logic [ENTRY_INDEX_W-1:0]  s_entry_index = '0;
    logic signed [FIELD_W-1:0] s_entry_value = '0;
    logic signed [FIELD_W-1:0] s_query_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [ENTRY_INDEX_W-1:0]  m_found_index;
    logic                      m_found;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [FIELD_W-1:0]        cfg_data = '0;

    // mirror of the block, updated on accepted beats
    logic signed [FIELD_W-1:0] axis_mirror [0:DEPTH-1];
    logic [TABLE_SIZE_W-1:0]   mirror_table_size = TABLE_SIZE_RST;
    logic [MAX_GAP_W-1:0]      mirror_max_gap = MAX_GAP_RST;

    axis_beat_t     request_fifo[$];
    lookup_result_t expected_lookups[$];
    axis_beat_t     next_beat;
    lookup_result_t want;

    // stimulus plan
    logic signed [FIELD_W-1:0] plan_axis [0:DEPTH-1];
    int                        gen_n;
    longint                    gen_step;
    logic [MAX_GAP_W-1:0]      gen_gap;
    int                        item_total = 0;
    bit                        count_items = 1'b1;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit rx_hold = 1'b0;
    int error_count = 0;

    nearest_axis_value_search dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_query_value (s_query_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found_index (m_found_index),
        .m_found       (m_found),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic lookup_result_t nearest_entry(input logic signed [FIELD_W-1:0] q);
        int             n;
        int             i;
        longint         best_gap;
        longint         d;
        bit             rising;
        bit             have;
        bit             done;
        lookup_result_t r;
        n = mirror_table_size;
        if (n == 0) n = 1;
        if (n > DEPTH) n = DEPTH;
        best_gap = longint'(mirror_max_gap);
        rising = axis_mirror[0] < axis_mirror[n-1];
        have = 1'b0;
        done = 1'b0;
        r = '0;
        for (i = 0; i < n && !done; i++) begin
            d = longint'(q) - longint'(axis_mirror[i]);
            if (d < 0) d = -d;
            if (rising ? (d <= best_gap) : (d < best_gap)) begin
                best_gap = d;
                r.found_index = i[ENTRY_INDEX_W-1:0];
                have = 1'b1;
            end else if (have) begin
                done = 1'b1;
            end
        end
        r.found = have;
        if (!have) r.found_index = '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t ns: %s", $time, what);
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_QUERY) begin
                    expected_lookups.push_back(nearest_entry(s_query_value));
                end else begin
                    axis_mirror[s_entry_index] = s_entry_value;
                end
            end
            if (!s_valid || s_ready) begin
                if (request_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = request_fifo.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= next_beat.req_type;
                    s_entry_index <= next_beat.entry_index;
                    s_entry_value <= next_beat.entry_value;
                    s_query_value <= next_beat.query_value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_lookups.size() == 0) begin
                    report_mismatch("result beat with no query outstanding");
                end else begin
                    want = expected_lookups.pop_front();
                    if (m_found !== want.found)
                        report_mismatch($sformatf("found %b, expected %b", m_found, want.found));
                    if (m_found_index !== want.found_index)
                        report_mismatch($sformatf("found_index %0d, expected %0d",
                            m_found_index, want.found_index));
                end
            end
            m_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_load(input logic [ENTRY_INDEX_W-1:0] idx,
                             input logic signed [FIELD_W-1:0] value);
        axis_beat_t b;
        b = '0;
        b.req_type = REQ_LOAD;
        b.entry_index = idx;
        b.entry_value = value;
        b.query_value = $urandom();
        request_fifo.push_back(b);
        plan_axis[idx] = value;
        if (count_items) item_total++;
    endtask

    task automatic push_query(input logic signed [FIELD_W-1:0] value);
        axis_beat_t b;
        b = '0;
        b.req_type = REQ_QUERY;
        b.entry_index = $urandom();
        b.entry_value = $urandom();
        b.query_value = value;
        request_fifo.push_back(b);
        if (count_items) item_total++;
    endtask

    task automatic wait_idle();
        while (request_fifo.size() != 0 || s_valid || expected_lookups.size() != 0)
            @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [FIELD_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TABLE_SIZE) mirror_table_size = data[TABLE_SIZE_W-1:0];
        else if (idx == CFG_MAX_GAP) mirror_max_gap = data[MAX_GAP_W-1:0];
    endtask

    task automatic configure(input logic [FIELD_W-1:0] size_word,
                             input logic [FIELD_W-1:0] gap_word);
        wait_idle();
        write_reg(CFG_TABLE_SIZE, size_word);
        write_reg(CFG_MAX_GAP, gap_word);
        gen_gap = gap_word[MAX_GAP_W-1:0];
        @(negedge aclk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 72;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                recv_stall_pct = 72;
            end
            default: begin
                send_idle_pct = 26;
                recv_stall_pct = 26;
            end
        endcase
    endtask

    function automatic longint pick_step(input int n);
        longint lim;
        longint s;
        lim = (n > 1) ? SPAN_MAX / (n - 1) : SPAN_MAX;
        case ($urandom_range(0, 5))
            0: s = 0;
            1: s = 65536;
            2, 3: s = 2 * longint'($urandom_range(1, 50000));
            4: s = longint'($urandom_range(0, lim[31:0]));
            default: s = lim;
        endcase
        if (s > lim) s = lim;
        return s;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_gap_word();
        logic [FIELD_W-1:0] w;
        longint             g;
        case ($urandom_range(0, 5))
            0, 1: g = gen_step;
            2: g = gen_step / 2;
            3: g = 0;
            4: g = VALUE_MAX;
            default: g = longint'($urandom_range(0, 32'h7FFF_FFFF));
        endcase
        if (g > VALUE_MAX) g = VALUE_MAX;
        w = $urandom();
        w[MAX_GAP_W-1:0] = g[MAX_GAP_W-1:0];
        return w;
    endfunction

    // monotonic axis over entries 0..gen_n-1
    task automatic load_axis(input bit falling);
        longint span;
        longint room;
        longint lowest;
        longint v;
        int     i;
        span = gen_step * (gen_n - 1);
        room = SPAN_MAX - span;
        lowest = VALUE_MIN + longint'($urandom_range(0, room[31:0]));
        for (i = 0; i < gen_n; i++) begin
            v = lowest + longint'(falling ? (gen_n - 1 - i) : i) * gen_step;
            push_load(i[ENTRY_INDEX_W-1:0], v[FIELD_W-1:0]);
        end
    endtask

    function automatic logic signed [FIELD_W-1:0] pick_query();
        longint v;
        longint off;
        int     j;
        j = $urandom_range(0, gen_n - 1);
        v = plan_axis[j];
        off = longint'($urandom_range(0, gen_gap));
        case ($urandom_range(0, 10))
            0, 1: v = v;
            2, 3: v = v + gen_step / 2;
            4: v = v - gen_step / 2;
            5, 6: v = v + off;
            7: v = v - off;
            8: v = v + longint'(gen_gap) + 1;
            9: v = longint'($urandom());
            default: v = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
        endcase
        return v[FIELD_W-1:0];
    endfunction

    initial begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial begin
        logic [FIELD_W-1:0] size_word;
        int                 phase;
        int                 idx;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ascending four-entry axis spanning the full value range, widest gap
        configure(32'hFFFF_F804, 32'hFFFF_FFFF);
        push_load(10'd0, 32'sh8000_0000);
        push_load(10'd1, -32'sd65536);
        push_load(10'd2, 32'sd65536);
        push_load(10'd3, 32'sh7FFF_FFFF);
        push_query(32'sd0);
        push_query(32'sh8000_0000);
        push_query(32'sh7FFF_FFFF);
        push_query(32'sd32768);

        // descending axis, ties need strict improvement
        configure(32'd4, 32'h8001_0001);
        push_load(10'd0, 32'sh7FFF_FFFF);
        push_load(10'd1, 32'sd65536);
        push_load(10'd2, -32'sd65536);
        push_load(10'd3, 32'sh8000_0000);
        push_query(32'sd0);
        push_query(32'sd65536);

        // zero size acts as a single entry, zero gap never matches
        configure(32'd0, 32'd0);
        push_load(10'd0, 32'sh0001_8000);
        push_query(32'sh0001_8000);
        wait_idle();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        @(negedge aclk);
        push_query(32'sh0001_8000);
        configure(32'd1, 32'hFFFF_FFFF);
        push_query(32'sh8000_0000);
        push_query(32'sh0001_0000);

        phase = 0;
        while (item_total < RANDOM_ITEMS) begin
            gen_n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            gen_step = pick_step(gen_n);
            size_word = $urandom();
            size_word[TABLE_SIZE_W-1:0] = gen_n[TABLE_SIZE_W-1:0];
            configure(size_word, pick_gap_word());
            set_idling(idle_mode_t'(phase % 4));
            load_axis($urandom_range(0, 1));
            repeat ($urandom_range(6, 20)) begin
                case ($urandom_range(0, 19))
                    0, 1: begin
                        idx = $urandom_range(0, DEPTH - 1);
                        push_load(idx[ENTRY_INDEX_W-1:0], $urandom());
                    end
                    2: push_query($urandom());
                    default: push_query(pick_query());
                endcase
            end
            phase++;
        end

        // receiver holds off while queries keep coming
        gen_n = 8;
        gen_step = pick_step(gen_n);
        configure(32'd8, 32'h7FFF_FFFF);
        set_idling(IDLE_NONE);
        load_axis(1'b0);
        rx_hold = 1'b1;
        repeat (12) push_query(pick_query());
        repeat (400) @(negedge aclk);
        rx_hold = 1'b0;

        // size above the table depth is clamped, last entry sets the direction, walk stops early
        count_items = 1'b0;
        gen_n = 16;
        gen_step = 2 * longint'($urandom_range(1, 2000000));
        configure(32'hFFFF_FFFF, gen_step[FIELD_W-1:0]);
        load_axis(1'b0);
        push_load(ENTRY_INDEX_W'(DEPTH - 1), 32'sh7FFF_FFFF);
        push_query(plan_axis[0]);
        push_query(plan_axis[5] + gen_step[FIELD_W-1:0] / 2);
        repeat (4) begin
            idx = $urandom_range(0, gen_n - 3);
            push_query(plan_axis[idx] + FIELD_W'($urandom_range(0, gen_gap)));
        end

        wait_idle();
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
